// ----- rtl/rrsha_pkg.sv -----
// Shared types, SHA-256 constants and round functions for the reduced-round hasher.
`default_nettype none
package rrsha_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] blk_t;
	typedef logic [7:0][31:0] st_t;

	// Control handed from the sequencer to the cell chains.
	typedef struct packed {
		logic load;
		logic step;
	} chain_ctl_t;

	localparam int MinRounds = 4;

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam st_t InitH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t PadWord  = 32'h80000000;
	localparam word_t LenBlk1  = 32'h00000280;
	localparam word_t LenBlk2  = 32'h00000100;

	function automatic word_t rotr(input word_t x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	// Leading zeros of a nonzero word; the highest set bit wins.
	function automatic logic [4:0] clz32(input word_t x);
		logic [4:0] r;
		r = '0;
		for (int b = 0; b < 32; b++) begin
			if (x[b]) begin
				r = 5'(31 - b);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rrsha_msg_sched.sv -----
// Message schedule: a chain of sixteen word cells that shifts one word per round.
`default_nettype none
module rrsha_msg_sched (
	input  wire                     clk,
	input  rrsha_pkg::chain_ctl_t   ctl,
	input  rrsha_pkg::blk_t         blk,
	output rrsha_pkg::word_t        w_cur
);
	import rrsha_pkg::*;

	blk_t  w_q;
	word_t w_new;

	// Next schedule word enters at the tail while the head is consumed.
	assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign w_cur = w_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			w_q <= blk;
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rrsha_round_core.sv -----
// Working-variable chain a..h with one compression round per step.
`default_nettype none
module rrsha_round_core (
	input  wire                     clk,
	input  rrsha_pkg::chain_ctl_t   ctl,
	input  rrsha_pkg::st_t          init,
	input  rrsha_pkg::word_t        k,
	input  rrsha_pkg::word_t        w,
	output rrsha_pkg::st_t          v
);
	import rrsha_pkg::*;

	st_t   v_q;
	word_t t1;
	word_t t2;

	// Round terms; v_q[0] is a and v_q[4] is e.
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + k + w;
	assign t2 = bsig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign v = v_q;

	// Each cell takes its neighbor's word; a and e take the new sums.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= init;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/reduced_round_sha256d_nonce_hasher_unit.sv -----
// Top level: sequencer for the two reduced-round compressions and zero count.
//
// Usage: drive the midstate, tail words and nonce with start high while busy
// is low; that edge accepts the beat. busy stays high until the result is
// shown. The result beat (hash words, leading_zero_count, hit) is on the
// outputs for exactly one cycle with done high; the receiver cannot stall it
// and must take it on that cycle.
// round_count is written with cfg_we/cfg_wdata; the user must write it only
// while the unit is idle, as the block does not enforce this. Values below
// 4 act as 4 and above MAX_ROUNDS act as MAX_ROUNDS. The next beat may be
// accepted on the cycle done is high. A beat passes through the single
// shared round cell chain (one round per cycle for each compression), a
// feed-forward state after each compression and a zero count that walks
// the eight hash words, one hash word per cycle.
// Reset (arst_n low) returns the sequencer to idle, drops done and sets
// round_count to 64.
`default_nettype none
module reduced_round_sha256d_nonce_hasher_unit #(
	parameter int MAX_ROUNDS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         cfg_we,
	input  wire  [6:0]  cfg_wdata,
	input  wire  [63:0] midstate_w01,
	input  wire  [63:0] midstate_w23,
	input  wire  [63:0] midstate_w45,
	input  wire  [63:0] midstate_w67,
	input  wire  [31:0] tail_w0,
	input  wire  [31:0] tail_w1,
	input  wire  [31:0] tail_w2,
	input  wire  [31:0] nonce,
	output logic        done,
	output logic [63:0] hash_w01,
	output logic [63:0] hash_w23,
	output logic [63:0] hash_w45,
	output logic [63:0] hash_w67,
	output logic [8:0]  leading_zero_count,
	output logic        hit
);
	import rrsha_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_C1, ST_FF1, ST_C2, ST_FF2, ST_LZ
	} state_t;

	state_t     state_q;
	logic [6:0] round_q;
	logic [6:0] rounds_eff;
	logic [5:0] last_rnd;
	logic [5:0] cnt_q;
	st_t        base_q;
	st_t        hash_q;
	logic [2:0] idx_q;
	logic [8:0] lz_q;
	logic [8:0] lz_nx;
	logic       found_q;
	logic       done_q;
	chain_ctl_t ctl;
	st_t        mid;
	st_t        v;
	st_t        sum;
	st_t        init;
	blk_t       blk;
	blk_t       blk1;
	blk_t       blk2;
	word_t      w;
	word_t      lz_word;

	// Clamp the configured round count.
	always_comb begin
		rounds_eff = round_q;
		if (round_q < 7'(MinRounds)) begin
			rounds_eff = 7'(MinRounds);
		end
		if (round_q > 7'(MAX_ROUNDS)) begin
			rounds_eff = 7'(MAX_ROUNDS);
		end
	end
	assign last_rnd = 6'(rounds_eff - 7'd1);

	assign mid = {midstate_w67[31:0], midstate_w67[63:32], midstate_w45[31:0],
		midstate_w45[63:32], midstate_w23[31:0], midstate_w23[63:32],
		midstate_w01[31:0], midstate_w01[63:32]};

	// Feed-forward of the working variables onto the chaining value.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sum[i] = base_q[i] + v[i];
		end
	end

	// Padded blocks for the inner and outer compressions.
	always_comb begin
		blk1     = '0;
		blk1[0]  = tail_w0;
		blk1[1]  = tail_w1;
		blk1[2]  = tail_w2;
		blk1[3]  = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
		blk1[4]  = PadWord;
		blk1[15] = LenBlk1;
		blk2     = '0;
		for (int i = 0; i < 8; i++) begin
			blk2[i] = sum[i];
		end
		blk2[8]  = PadWord;
		blk2[15] = LenBlk2;
	end

	assign busy = (state_q != ST_IDLE);
	assign ctl  = '{load: ((state_q == ST_IDLE) && start) || (state_q == ST_FF1),
		step: (state_q == ST_C1) || (state_q == ST_C2)};
	assign init = (state_q == ST_IDLE) ? mid : InitH;
	assign blk  = (state_q == ST_IDLE) ? blk1 : blk2;

	rrsha_msg_sched u_sched (
		.clk   (clk),
		.ctl   (ctl),
		.blk   (blk),
		.w_cur (w)
	);

	rrsha_round_core u_core (
		.clk  (clk),
		.ctl  (ctl),
		.init (init),
		.k    (RoundK[cnt_q]),
		.w    (w),
		.v    (v)
	);

	// Zero count walks one hash word per cycle from word 0.
	assign lz_word = hash_q[idx_q];
	always_comb begin
		lz_nx = lz_q;
		if (!found_q) begin
			if (lz_word != '0) begin
				lz_nx = lz_q + {4'd0, clz32(lz_word)};
			end else begin
				lz_nx = lz_q + 9'd32;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= 7'd64;
		end else if (cfg_we) begin
			round_q <= cfg_wdata;
		end
	end

	// Sequencer with registered result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			lz_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						base_q  <= mid;
						cnt_q   <= '0;
						state_q <= ST_C1;
					end
				end
				ST_C1: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == last_rnd) begin
						state_q <= ST_FF1;
					end
				end
				ST_FF1: begin
					base_q  <= InitH;
					cnt_q   <= '0;
					state_q <= ST_C2;
				end
				ST_C2: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == last_rnd) begin
						state_q <= ST_FF2;
					end
				end
				ST_FF2: begin
					hash_q  <= sum;
					lz_q    <= '0;
					found_q <= 1'b0;
					idx_q   <= '0;
					state_q <= ST_LZ;
				end
				ST_LZ: begin
					lz_q  <= lz_nx;
					idx_q <= idx_q + 3'd1;
					if (lz_word != '0) begin
						found_q <= 1'b1;
					end
					if (idx_q == 3'd7) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done               = done_q;
	assign hash_w01           = {hash_q[0], hash_q[1]};
	assign hash_w23           = {hash_q[2], hash_q[3]};
	assign hash_w45           = {hash_q[4], hash_q[5]};
	assign hash_w67           = {hash_q[6], hash_q[7]};
	assign leading_zero_count = lz_q;
	assign hit                = (lz_q != '0);

	// A result beat only appears once the sequencer is back in idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	// An accepted beat starts the inner compression.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && state_q == ST_C1)) else $error("start not taken");

	// The zero count never passes the hash width.
	a_lz_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (leading_zero_count <= 9'd256)) else $error("zero count out of range");

	// The round counter never runs past the clamped round count.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C1 || state_q == ST_C2) |-> (cnt_q <= last_rnd))
		else $error("round counter overran");

	// done lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
endmodule
`default_nettype wire

// ----- bench/tb_reduced_round_sha256d_nonce_hasher_unit.sv -----
// Testbench for the reduced-round double SHA-256 nonce hasher with a built-in hash predictor.
`default_nettype none
module tb_reduced_round_sha256d_nonce_hasher_unit;
	import rrsha_pkg::*;

	typedef struct packed {
		logic [3:0][63:0] mid;
		logic [2:0][31:0] tail;
		logic [31:0]      nonce;
	} nonce_job_t;

	typedef struct packed {
		logic [3:0][63:0] hash;
		logic [8:0]       lzc;
		logic             hit;
	} hash_out_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	logic [63:0] midstate_w01, midstate_w23, midstate_w45, midstate_w67;
	logic [31:0] tail_w0, tail_w1, tail_w2, nonce;
	logic        done;
	logic [63:0] hash_w01, hash_w23, hash_w45, hash_w67;
	logic [8:0]  leading_zero_count;
	logic        hit;

	hash_out_t   expected_hashes [$];
	logic [6:0]  round_reg;
	int          sender_idle_pct;
	int          mismatch_count;

	reduced_round_sha256d_nonce_hasher_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.midstate_w01(midstate_w01), .midstate_w23(midstate_w23),
		.midstate_w45(midstate_w45), .midstate_w67(midstate_w67),
		.tail_w0(tail_w0), .tail_w1(tail_w1), .tail_w2(tail_w2), .nonce(nonce),
		.done(done), .hash_w01(hash_w01), .hash_w23(hash_w23),
		.hash_w45(hash_w45), .hash_w67(hash_w67),
		.leading_zero_count(leading_zero_count), .hit(hit)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Overall run limit.
	initial begin
		#40000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic word_t ror32(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One compression with a reduced number of rounds, including feed-forward.
	function automatic st_t compress_rounds(input st_t init, input blk_t blk, input int rounds);
		word_t w [64];
		word_t v [8];
		word_t t1, t2, ch, mj;
		st_t   res;
		for (int i = 0; i < 16; i++) begin
			w[i] = blk[i];
		end
		for (int i = 16; i < 64; i++) begin
			w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		end
		for (int i = 0; i < 8; i++) begin
			v[i] = init[i];
		end
		for (int i = 0; i < rounds; i++) begin
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
				+ RoundK[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) begin
			res[i] = init[i] + v[i];
		end
		return res;
	endfunction

	// Full double hash of one nonce candidate at the current round setting.
	function automatic hash_out_t hash_nonce(input nonce_job_t job, input logic [6:0] rc);
		int        rounds;
		st_t       inner, outer;
		blk_t      blk;
		hash_out_t r;
		logic      found;
		rounds = (rc < 4) ? 4 : (rc > 64) ? 64 : int'(rc);
		for (int i = 0; i < 4; i++) begin
			inner[2*i]   = job.mid[i][63:32];
			inner[2*i+1] = job.mid[i][31:0];
		end
		blk = '0;
		blk[0] = job.tail[0];
		blk[1] = job.tail[1];
		blk[2] = job.tail[2];
		blk[3] = {job.nonce[7:0], job.nonce[15:8], job.nonce[23:16], job.nonce[31:24]};
		blk[4] = PadWord;
		blk[15] = LenBlk1;
		inner = compress_rounds(inner, blk, rounds);
		blk = '0;
		for (int i = 0; i < 8; i++) begin
			blk[i] = inner[i];
		end
		blk[8] = PadWord;
		blk[15] = LenBlk2;
		outer = compress_rounds(InitH, blk, rounds);
		for (int i = 0; i < 4; i++) begin
			r.hash[i] = {outer[2*i], outer[2*i+1]};
		end
		// Count zeros from the top bit of word 0 down to the end of word 7.
		r.lzc = 9'd0;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			for (int b = 31; b >= 0; b--) begin
				if (!found) begin
					if (outer[i][b]) found = 1'b1;
					else r.lzc = r.lzc + 9'd1;
				end
			end
		end
		r.hit = (r.lzc != 0);
		return r;
	endfunction

	// Result checker: every done beat is compared with the oldest expectation.
	always @(posedge clk) begin
		hash_out_t got, want;
		if (arst_n && done) begin
			got.hash = {hash_w67, hash_w45, hash_w23, hash_w01};
			got.lzc = leading_zero_count;
			got.hit = hit;
			if (expected_hashes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result beat: hash %h lzc %0d hit %0d",
						got.hash, got.lzc, got.hit);
			end else begin
				want = expected_hashes.pop_front();
				if (got != want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch: expected hash %h lzc %0d hit %0d",
							want.hash, want.lzc, want.hit);
						$display("          actual   hash %h lzc %0d hit %0d",
							got.hash, got.lzc, got.hit);
					end
				end
			end
		end
	end

	// Send one beat, wait for its acceptance, then idle at random.
	task automatic send_job(input nonce_job_t job);
		midstate_w01 <= job.mid[0];
		midstate_w23 <= job.mid[1];
		midstate_w45 <= job.mid[2];
		midstate_w67 <= job.mid[3];
		tail_w0 <= job.tail[0];
		tail_w1 <= job.tail[1];
		tail_w2 <= job.tail[2];
		nonce <= job.nonce;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_hashes.push_back(hash_nonce(job, round_reg));
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Write the round count once the unit has drained.
	task automatic set_round_count(input logic [6:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (expected_hashes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		round_reg = value;
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic nonce_job_t random_job();
		nonce_job_t  j;
		logic [63:0] r;
		for (int i = 0; i < 4; i++) begin
			j.mid[i] = rand64();
		end
		for (int i = 0; i < 3; i++) begin
			r = rand64();
			j.tail[i] = r[31:0];
		end
		j.nonce = $urandom;
		return j;
	endfunction

	function automatic int behold_count();
		return 62 + $urandom_range(8);
	endfunction

	// Field extremes and byte order of the nonce at the reset round count.
	task automatic test_directed();
		nonce_job_t j;
		j = '0;
		send_job(j);
		j = '1;
		send_job(j);
		j = '0;
		j.nonce = 32'h01020304;
		send_job(j);
		j.nonce = 32'h80000001;
		send_job(j);
		j = '1;
		j.nonce = '0;
		send_job(j);
		j = '0;
		j.mid = {64'h5be0cd191f83d9ab, 64'h9b05688c510e527f,
			64'ha54ff53a3c6ef372, 64'hbb67ae856a09e667};
		j.tail = {32'hffffffff, 32'h00000000, 32'haaaaaaaa};
		send_job(j);
		repeat (4) send_job(random_job());
	endtask

	// Round counts at, below and above the legal range.
	task automatic test_round_limits();
		logic [6:0] settings [8] = '{7'd4, 7'd0, 7'd3, 7'd64, 7'd65, 7'd127, 7'd5, 7'd63};
		nonce_job_t j;
		foreach (settings[s]) begin
			set_round_count(settings[s]);
			j = '0;
			send_job(j);
			j = '1;
			send_job(j);
			send_job(random_job());
		end
	endtask

	// Random beats over several round settings and idling patterns.
	task automatic test_random_traffic();
		int idle_plan [3] = '{25, 63, 0};
		foreach (idle_plan[p]) begin
			sender_idle_pct = idle_plan[p];
			for (int s = 0; s < 4; s++) begin
				set_round_count((s == 0) ? 7'd4 : 7'($urandom_range(127)));
				repeat (behold_count()) send_job(random_job());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		midstate_w01 = '0;
		midstate_w23 = '0;
		midstate_w45 = '0;
		midstate_w67 = '0;
		tail_w0 = '0;
		tail_w1 = '0;
		tail_w2 = '0;
		nonce = '0;
		round_reg = 7'd64;
		sender_idle_pct = 25;
		mismatch_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_round_limits();
		test_random_traffic();

		start <= 1'b0;
		@(posedge clk);
		while (expected_hashes.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/rrsha_pkg.sv
rtl/rrsha_msg_sched.sv
rtl/rrsha_round_core.sv
rtl/reduced_round_sha256d_nonce_hasher_unit.sv
bench/tb_reduced_round_sha256d_nonce_hasher_unit.sv
